FILE: rtl/pss_pkg.sv
`timescale 1ns / 1ps
package pss_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PRIME_TIMEOUT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_PERIOD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_PRIME      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_FLOW_TIMEOUT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_FLOW_RATE    = 3'd4;

  localparam logic [19:0] PRIME_TIMEOUT_RST    = 20'd6000;
  localparam logic [19:0] STABLE_PERIOD_RST    = 20'd500;
  localparam logic [19:0] EXTRA_PRIME_RST      = 20'd2000;
  localparam logic [19:0] LOW_FLOW_TIMEOUT_RST = 20'd5000;
  localparam logic [15:0] MIN_FLOW_RATE_RST    = 16'd80;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_OVERFLOW  = 3'd1;
  localparam logic [2:0] EV_LOW_FLOW  = 3'd2;
  localparam logic [2:0] EV_NO_LIQUID = 3'd3;
  localparam logic [2:0] EV_COMPLETE  = 3'd4;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_AWAIT    = 2'd1;
  localparam logic [1:0] PH_CONFIRM  = 2'd2;
  localparam logic [1:0] PH_EXTRA    = 2'd3;

  // what the back end does with a queued tick
  localparam logic [1:0] KIND_SKIP  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]  channel;
    logic [31:0] now_ms;
    logic        priming_active;
    logic [15:0] flow_rate;
    logic        overflow;
    logic        liquid_present;
  } tick_t;

  typedef struct packed {
    logic [1:0] channel_out;
    logic [2:0] event_res;
    logic       stop_priming;
    logic [1:0] phase;
  } result_t;

  typedef struct packed {
    logic [19:0] prime_window_ms;
    logic [19:0] stable_period_ms;
    logic [19:0] extra_prime_ms;
    logic [19:0] low_flow_timeout_ms;
    logic [15:0] min_flow_rate;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic [31:0] now_ms;
    logic        flow_low;
    logic        overflow;
    logic        liquid_present;
  } cmd_t;

endpackage

FILE: rtl/pss_front.sv
`timescale 1ns / 1ps
module pss_front #(
  parameter int CHANNELS = 4
) (
  input  pss_pkg::tick_t tick,
  input  logic           in_valid,
  output logic           in_ready,
  input  pss_pkg::cfg_t  cfg,
  output pss_pkg::cmd_t  cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);

  always_comb begin
    cmd.channel        = tick.channel;
    cmd.now_ms         = tick.now_ms;
    cmd.flow_low       = tick.flow_rate < cfg.min_flow_rate;
    cmd.overflow       = tick.overflow;
    cmd.liquid_present = tick.liquid_present;
    if (32'(tick.channel) >= CHANNELS) begin
      cmd.kind = pss_pkg::KIND_SKIP;
    end else if (!tick.priming_active) begin
      cmd.kind = pss_pkg::KIND_CLEAR;
    end else begin
      cmd.kind = pss_pkg::KIND_RUN;
    end
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

FILE: rtl/pss_queue.sv
`timescale 1ns / 1ps
module pss_queue (
  input  logic          clk,
  input  logic          rst,
  input  pss_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output pss_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);

  pss_pkg::cmd_t mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule

FILE: rtl/pss_back.sv
`timescale 1ns / 1ps
module pss_back #(
  parameter int CHANNELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  pss_pkg::cfg_t    cfg,
  input  pss_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  output pss_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready
);

  logic [31:0] start_stamp    [CHANNELS];
  logic [31:0] stable_stamp   [CHANNELS];
  logic [31:0] extra_stamp    [CHANNELS];
  logic [31:0] low_flow_stamp [CHANNELS];
  logic [CHANNELS-1:0] start_valid;
  logic [CHANNELS-1:0] stable_valid;
  logic [CHANNELS-1:0] extra_valid;
  logic [CHANNELS-1:0] low_flow_valid;
  logic [CHANNELS-1:0] finished_flag;

  logic [CHANNELS-1:0] hit;
  logic        pop;

  // selected channel state
  logic        sv, stv, exv, lfv, fin;
  logic [31:0] ss, sts, exs, lfs;
  logic [31:0] e_start, e_low, e_stab, e_ext;

  logic        start_valid_next, stable_valid_next, extra_valid_next;
  logic        low_flow_valid_next, finished_flag_next;
  logic [31:0] start_stamp_next, stable_stamp_next, extra_stamp_next, low_flow_stamp_next;
  logic [2:0]  ev;
  logic [1:0]  ph;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      hit[i] = 32'(cmd.channel) == i;
    end
  end

  always_comb begin
    sv  = 1'b0;
    stv = 1'b0;
    exv = 1'b0;
    lfv = 1'b0;
    fin = 1'b0;
    ss  = '0;
    sts = '0;
    exs = '0;
    lfs = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (hit[i]) begin
        sv  = start_valid[i];
        stv = stable_valid[i];
        exv = extra_valid[i];
        lfv = low_flow_valid[i];
        fin = finished_flag[i];
        ss  = start_stamp[i];
        sts = stable_stamp[i];
        exs = extra_stamp[i];
        lfs = low_flow_stamp[i];
      end
    end
  end

  always_comb begin
    start_stamp_next    = sv ? ss : cmd.now_ms;
    e_start             = cmd.now_ms - start_stamp_next;
    e_low               = cmd.now_ms - lfs;
    e_stab              = cmd.now_ms - sts;
    // an extra period opened on this tick has zero elapsed time
    e_ext               = exv ? (cmd.now_ms - exs) : 32'd0;
    start_valid_next    = 1'b1;
    stable_valid_next   = stv;
    stable_stamp_next   = sts;
    extra_valid_next    = exv;
    extra_stamp_next    = exs;
    low_flow_valid_next = lfv;
    low_flow_stamp_next = lfs;
    finished_flag_next  = fin;
    ev                  = pss_pkg::EV_NONE;
    ph                  = pss_pkg::PH_IDLE;

    if (cmd.overflow) begin
      ev = pss_pkg::EV_OVERFLOW;
    end else begin
      if (cmd.flow_low) begin
        if (!lfv) begin
          low_flow_valid_next = 1'b1;
          low_flow_stamp_next = cmd.now_ms;
        end else if (e_low >= {12'd0, cfg.low_flow_timeout_ms}) begin
          ev = pss_pkg::EV_LOW_FLOW;
        end
      end else begin
        low_flow_valid_next = 1'b0;
      end
      if (ev == pss_pkg::EV_NONE && !fin) begin
        if (cmd.liquid_present) begin
          if (!stv) begin
            stable_valid_next = 1'b1;
            stable_stamp_next = cmd.now_ms;
          end else if (e_stab >= {12'd0, cfg.stable_period_ms} && !exv) begin
            extra_valid_next = 1'b1;
            extra_stamp_next = cmd.now_ms;
            start_valid_next = 1'b0;
          end
        end else begin
          stable_valid_next = 1'b0;
          if (e_start >= {12'd0, cfg.prime_window_ms}) begin
            ev = pss_pkg::EV_NO_LIQUID;
          end
        end
      end
      if (ev == pss_pkg::EV_NONE && extra_valid_next &&
          e_ext >= {12'd0, cfg.extra_prime_ms}) begin
        ev = pss_pkg::EV_COMPLETE;
      end
    end

    if (ev != pss_pkg::EV_NONE) begin
      start_valid_next    = 1'b0;
      stable_valid_next   = 1'b0;
      extra_valid_next    = 1'b0;
      low_flow_valid_next = 1'b0;
      finished_flag_next  = (ev == pss_pkg::EV_OVERFLOW) || (ev == pss_pkg::EV_LOW_FLOW);
    end else if (!finished_flag_next) begin
      if (extra_valid_next) begin
        ph = pss_pkg::PH_EXTRA;
      end else if (stable_valid_next) begin
        ph = pss_pkg::PH_CONFIRM;
      end else begin
        ph = pss_pkg::PH_AWAIT;
      end
    end
  end

  // channel flags and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      start_valid    <= '0;
      stable_valid   <= '0;
      extra_valid    <= '0;
      low_flow_valid <= '0;
      finished_flag  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (hit[i]) begin
            case (cmd.kind)
              pss_pkg::KIND_CLEAR: begin
                start_valid[i]    <= 1'b0;
                stable_valid[i]   <= 1'b0;
                extra_valid[i]    <= 1'b0;
                low_flow_valid[i] <= 1'b0;
                finished_flag[i]  <= 1'b0;
              end
              pss_pkg::KIND_RUN: begin
                start_valid[i]    <= start_valid_next;
                stable_valid[i]   <= stable_valid_next;
                extra_valid[i]    <= extra_valid_next;
                low_flow_valid[i] <= low_flow_valid_next;
                finished_flag[i]  <= finished_flag_next;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // stamps only mean anything under their valid bits
  always_ff @(posedge clk) begin
    if (pop && cmd.kind == pss_pkg::KIND_RUN) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (hit[i]) begin
          start_stamp[i]    <= start_stamp_next;
          stable_stamp[i]   <= stable_stamp_next;
          extra_stamp[i]    <= extra_stamp_next;
          low_flow_stamp[i] <= low_flow_stamp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.channel_out <= cmd.channel;
      if (cmd.kind == pss_pkg::KIND_RUN) begin
        result.event_res    <= ev;
        result.stop_priming <= ev != pss_pkg::EV_NONE;
        result.phase        <= ph;
      end else begin
        result.event_res    <= pss_pkg::EV_NONE;
        result.stop_priming <= 1'b0;
        result.phase        <= pss_pkg::PH_IDLE;
      end
    end
  end

endmodule

FILE: rtl/prime_sequence_supervisor_top.sv
`timescale 1ns / 1ps
// channel   | handshake               | payload
// ----------+-------------------------+--------------------------------------
// tick in   | in_valid / in_ready     | tick   (pss_pkg::tick_t)
// result    | out_valid / out_ready   | result (pss_pkg::result_t)
// config    | cfg_write               | cfg_index, cfg_data
//
// one tick per cycle sustained while out_ready is high; a result is valid once its
// tick has passed the queue entry and then the state update into the output register
// the per-channel read-modify-write of state in the back end sets that rate
// a stalled result holds the back end, the queue absorbs two more ticks
// synchronous reset loads the default timeouts and clears every channel
module prime_sequence_supervisor_top #(
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pss_pkg::tick_t                  tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pss_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pss_pkg::cfg_t cfg;
  pss_pkg::cmd_t front_cmd;
  pss_pkg::cmd_t back_cmd;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prime_window_ms     <= pss_pkg::PRIME_TIMEOUT_RST;
      cfg.stable_period_ms    <= pss_pkg::STABLE_PERIOD_RST;
      cfg.extra_prime_ms      <= pss_pkg::EXTRA_PRIME_RST;
      cfg.low_flow_timeout_ms <= pss_pkg::LOW_FLOW_TIMEOUT_RST;
      cfg.min_flow_rate       <= pss_pkg::MIN_FLOW_RATE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pss_pkg::REG_PRIME_TIMEOUT:    cfg.prime_window_ms     <= cfg_data;
        pss_pkg::REG_STABLE_PERIOD:    cfg.stable_period_ms    <= cfg_data;
        pss_pkg::REG_EXTRA_PRIME:      cfg.extra_prime_ms      <= cfg_data;
        pss_pkg::REG_LOW_FLOW_TIMEOUT: cfg.low_flow_timeout_ms <= cfg_data;
        pss_pkg::REG_MIN_FLOW_RATE:    cfg.min_flow_rate       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pss_front #(.CHANNELS(CHANNELS)) u_front (
    .tick      (tick),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg       (cfg),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  pss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  pss_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

FILE: rtl/pss_checker.sv
`timescale 1ns / 1ps
module pss_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input pss_pkg::result_t result
);

  // stop flag follows the event code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.stop_priming == (result.event_res != pss_pkg::EV_NONE)))
    else $error("stop_priming disagrees with event_res");

  // a terminal event leaves the channel idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.event_res != pss_pkg::EV_NONE) |-> result.phase == pss_pkg::PH_IDLE)
    else $error("phase not idle on terminal event");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.event_res == pss_pkg::EV_NONE ||
                   result.event_res == pss_pkg::EV_OVERFLOW ||
                   result.event_res == pss_pkg::EV_LOW_FLOW ||
                   result.event_res == pss_pkg::EV_NO_LIQUID ||
                   result.event_res == pss_pkg::EV_COMPLETE))
    else $error("event_res out of range");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind prime_sequence_supervisor_top pss_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result)
);
